### hdl/bpa_pkg.sv
// Shared constants for the buddy page allocator: default sizes, field widths
// and operation codes. No dependencies.
package bpa_pkg;

	localparam int PAGE_COUNT_DEF  = 1024;
	localparam int ORDER_COUNT_DEF = 11;

	localparam int OP_W  = 2;
	localparam int ORD_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_ADD   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

endpackage

### hdl/bpa_if.sv
// Request and response channel interfaces of the buddy page allocator.
// Depends on bpa_pkg for the operation and order widths.
interface bpa_req_if import bpa_pkg::*; #(parameter int PW = 10);
	logic            valid;
	logic            ready;
	logic [OP_W-1:0]  operation;
	logic [ORD_W-1:0] order;
	logic [PW-1:0]    page_index;

	modport source(output valid, output operation, output order, output page_index,
		input ready);
	modport sink(input valid, input operation, input order, input page_index,
		output ready);
endinterface

interface bpa_rsp_if #(parameter int PW = 10);
	logic          valid;
	logic          ready;
	logic [PW-1:0] block_index;
	logic          ok;
	logic [PW:0]   pages_free;

	modport source(output valid, output block_index, output ok, output pages_free,
		input ready);
	modport sink(input valid, input block_index, input ok, input pages_free,
		output ready);
endinterface

### hdl/buddy_page_allocator.sv
// Buddy page allocator top level. Depends on bpa_pkg and the bpa_req_if and
// bpa_rsp_if interfaces.
//
// One word in, one word out. The per-page state (free flag, order, list links)
// lives in one single-port-style page memory with a registered read, one access
// per cycle; list updates are read-modify-writes through it, but a push writes
// the new head entry whole. List heads and the free count are flip-flops. After
// reset a clearing pass writes every page entry, during which no request is taken.
// An add pushes the block onto its order's list; an allocate scans up from the
// asked order, unlinks the first block found, pushes the upper half per split and
// writes the final order; a free merges with free buddies of its order, then pushes.
// Next request is taken once the result is in the output register, collected or not.
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
	parameter int ORDER_COUNT = ORDER_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);

	localparam int PW = $clog2(PAGE_COUNT);
	localparam int LW = PW + 1;
	localparam int OW = $clog2(ORDER_COUNT + 1);
	localparam int HW = $clog2(ORDER_COUNT);
	localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);

	typedef struct packed {
		logic          free;
		logic [OW-1:0] ord;
		logic [LW-1:0] nxt;
		logic [LW-1:0] prv;
	} entry_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_DONE,
		ST_AL_SCAN, ST_AL_RD, ST_AL_CLRF, ST_AL_SPLIT, ST_AL_ORD_RD, ST_AL_ORD_WR,
		ST_UL_P, ST_UL_P_WR, ST_UL_N, ST_UL_N_WR,
		ST_PU_WR, ST_PU_H_RD, ST_PU_H_WR,
		ST_FR_RD, ST_FR_ORD, ST_FR_LOOP, ST_FR_CHK, ST_FR_BCLR_RD, ST_FR_BCLR_WR
	} state_t;

	state_t        state_q;
	op_t           op_q;
	logic [OW-1:0] want_q;
	logic [OW-1:0] ord_q;
	logic [PW-1:0] pg_q;
	logic [PW-1:0] pa_q;
	logic [PW-1:0] bud_q;
	logic [PW-1:0] clr_q;
	logic [LW-1:0] h_q;
	logic [LW-1:0] p_q;
	logic [LW-1:0] nx_q;
	logic [LW-1:0] head_q [ORDER_COUNT];
	logic [LW-1:0] total_q;
	logic          res_ok_q;
	logic [PW-1:0] res_idx_q;
	logic          out_valid_q;
	logic [PW-1:0] out_idx_q;
	logic          out_ok_q;
	logic [LW-1:0] out_total_q;

	entry_t        page_mem_q [PAGE_COUNT];
	entry_t        rd_q;

	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	entry_t        wr_data;
	logic [PW-1:0] bud_c;
	logic [LW-1:0] head_c;
	logic [OW-1:0] in_ord;
	logic          in_ord_ok;

	assign bud_c     = pg_q ^ (PW'(1) << ord_q);
	assign head_c    = head_q[ord_q[HW-1:0]];
	assign in_ord    = OW'(req.order);
	assign in_ord_ok = int'(req.order) < ORDER_COUNT;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.block_index = out_idx_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.pages_free  = out_total_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pg_q;
		wr_en   = 1'b0;
		wr_addr = pg_q;
		wr_data = rd_q;
		case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_AL_RD, ST_FR_RD, ST_AL_ORD_RD: begin
				rd_en = 1'b1;
			end
			ST_AL_CLRF: begin
				wr_en        = 1'b1;
				wr_data.free = 1'b0;
			end
			ST_UL_P: begin
				rd_en   = !p_q[PW];
				rd_addr = p_q[PW-1:0];
			end
			ST_UL_P_WR: begin
				wr_en       = 1'b1;
				wr_addr     = p_q[PW-1:0];
				wr_data.nxt = nx_q;
			end
			ST_UL_N: begin
				rd_en   = !nx_q[PW];
				rd_addr = nx_q[PW-1:0];
			end
			ST_UL_N_WR: begin
				wr_en       = 1'b1;
				wr_addr     = nx_q[PW-1:0];
				wr_data.prv = p_q;
			end
			ST_PU_WR: begin
				wr_en   = 1'b1;
				wr_addr = pa_q;
				wr_data = '{free: 1'b1, ord: ord_q, nxt: head_c, prv: NIL};
			end
			ST_PU_H_RD: begin
				rd_en   = 1'b1;
				rd_addr = h_q[PW-1:0];
			end
			ST_PU_H_WR: begin
				wr_en       = 1'b1;
				wr_addr     = h_q[PW-1:0];
				wr_data.prv = {1'b0, pa_q};
			end
			ST_AL_ORD_WR: begin
				wr_en       = 1'b1;
				wr_data.ord = want_q;
			end
			ST_FR_LOOP: begin
				rd_en   = int'(ord_q) < ORDER_COUNT - 1;
				rd_addr = bud_c;
			end
			ST_FR_BCLR_RD: begin
				rd_en   = 1'b1;
				rd_addr = bud_q;
			end
			ST_FR_BCLR_WR: begin
				wr_en        = 1'b1;
				wr_addr      = bud_q;
				wr_data.free = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= page_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			op_q        <= OP_NONE;
			want_q      <= '0;
			ord_q       <= '0;
			pg_q        <= '0;
			pa_q        <= '0;
			bud_q       <= '0;
			clr_q       <= '0;
			h_q         <= NIL;
			p_q         <= NIL;
			nx_q        <= NIL;
			total_q     <= '0;
			res_ok_q    <= 1'b0;
			res_idx_q   <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_ok_q    <= 1'b0;
			out_total_q <= '0;
			for (int k = 0; k < ORDER_COUNT; k++) begin
				head_q[k] <= NIL;
			end
		end else begin
			if (out_valid_q && rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PW'(PAGE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						op_q      <= op_t'(req.operation);
						want_q    <= in_ord;
						ord_q     <= in_ord;
						pg_q      <= req.page_index;
						pa_q      <= req.page_index;
						res_ok_q  <= 1'b0;
						res_idx_q <= '0;
						case (op_t'(req.operation))
							OP_ALLOC: state_q <= in_ord_ok ? ST_AL_SCAN : ST_DONE;
							OP_FREE:  state_q <= ST_FR_RD;
							OP_ADD: begin
								if (in_ord_ok) begin
									total_q <= total_q + (LW'(1) << in_ord);
									state_q <= ST_PU_WR;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_ok_q    <= res_ok_q;
						out_total_q <= total_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_AL_SCAN: begin
					if (int'(ord_q) >= ORDER_COUNT) begin
						state_q <= ST_DONE;
					end else if (head_c[PW]) begin
						ord_q <= ord_q + 1'b1;
					end else begin
						pg_q    <= head_c[PW-1:0];
						state_q <= ST_AL_RD;
					end
				end
				ST_AL_RD: state_q <= ST_AL_CLRF;
				ST_AL_CLRF: begin
					p_q     <= rd_q.prv;
					nx_q    <= rd_q.nxt;
					state_q <= ST_UL_P;
				end
				ST_UL_P: begin
					if (!p_q[PW]) begin
						state_q <= ST_UL_P_WR;
					end else begin
						head_q[ord_q[HW-1:0]] <= nx_q;
						state_q               <= ST_UL_N;
					end
				end
				ST_UL_P_WR: state_q <= ST_UL_N;
				ST_UL_N: begin
					if (!nx_q[PW]) begin
						state_q <= ST_UL_N_WR;
					end else begin
						state_q <= (op_q == OP_ALLOC) ? ST_AL_SPLIT : ST_FR_BCLR_RD;
					end
				end
				ST_UL_N_WR: state_q <= (op_q == OP_ALLOC) ? ST_AL_SPLIT : ST_FR_BCLR_RD;
				ST_AL_SPLIT: begin
					if (ord_q > want_q) begin
						ord_q   <= ord_q - 1'b1;
						pa_q    <= pg_q + (PW'(1) << (ord_q - 1'b1));
						state_q <= ST_PU_WR;
					end else begin
						total_q <= total_q - (LW'(1) << want_q);
						state_q <= ST_AL_ORD_RD;
					end
				end
				ST_AL_ORD_RD: state_q <= ST_AL_ORD_WR;
				ST_AL_ORD_WR: begin
					res_ok_q  <= 1'b1;
					res_idx_q <= pg_q;
					state_q   <= ST_DONE;
				end
				ST_PU_WR: begin
					h_q                   <= head_c;
					head_q[ord_q[HW-1:0]] <= {1'b0, pa_q};
					if (!head_c[PW]) begin
						state_q <= ST_PU_H_RD;
					end else if (op_q == OP_ALLOC) begin
						state_q <= ST_AL_SPLIT;
					end else begin
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_PU_H_RD: state_q <= ST_PU_H_WR;
				ST_PU_H_WR: begin
					if (op_q == OP_ALLOC) begin
						state_q <= ST_AL_SPLIT;
					end else begin
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_FR_RD: state_q <= ST_FR_ORD;
				ST_FR_ORD: begin
					if (int'(rd_q.ord) >= ORDER_COUNT) begin
						state_q <= ST_DONE;
					end else begin
						ord_q   <= rd_q.ord;
						total_q <= total_q + (LW'(1) << rd_q.ord);
						state_q <= ST_FR_LOOP;
					end
				end
				ST_FR_LOOP: begin
					if (int'(ord_q) < ORDER_COUNT - 1) begin
						bud_q   <= bud_c;
						state_q <= ST_FR_CHK;
					end else begin
						pa_q    <= pg_q;
						state_q <= ST_PU_WR;
					end
				end
				ST_FR_CHK: begin
					if (!rd_q.free || rd_q.ord != ord_q) begin
						pa_q    <= pg_q;
						state_q <= ST_PU_WR;
					end else begin
						p_q     <= rd_q.prv;
						nx_q    <= rd_q.nxt;
						state_q <= ST_UL_P;
					end
				end
				ST_FR_BCLR_RD: state_q <= ST_FR_BCLR_WR;
				ST_FR_BCLR_WR: begin
					pg_q    <= pg_q & ~(PW'(1) << ord_q);
					ord_q   <= ord_q + 1'b1;
					state_q <= ST_FR_LOOP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fail_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ok) |-> (rsp.block_index == '0))
		else $error("failed result carries a nonzero block index");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("page memory written while idle");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AL_SCAN) |-> (int'(ord_q) <= ORDER_COUNT))
		else $error("order scan ran past the top list");

	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !rsp.ready) |=> (state_q == ST_DONE))
		else $error("result dropped while output register was full");

endmodule
